// ===== hdl/vfcm_pkg.sv =====
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared types, constants and helper functions for the voxel face culling
// mesher: chunk geometry, command codes, face order and coordinate helpers.
// ----------------------------------------------------------------------------
package vfcm_pkg;

    // Chunk geometry.
    localparam int CHUNK_W     = 16;
    localparam int CHUNK_H     = 64;
    localparam int CHUNK_D     = 16;
    localparam int VOXEL_COUNT = CHUNK_W * CHUNK_H * CHUNK_D;
    localparam int VOXEL_AW    = (VOXEL_COUNT > 1) ? $clog2(VOXEL_COUNT) : 1;

    localparam int TYPE_W    = 6;
    localparam int MASK_W    = 64;
    localparam int COUNTER_W = 14;
    localparam int VBASE_W   = 16;
    localparam int FACE_W    = 3;
    localparam int NUM_FACES = 6;

    // Command codes.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_MESH  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Face codes, in emission order.
    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Z  = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Z  = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NEG_X  = 3'd4;
    localparam logic [FACE_W-1:0] FACE_POS_X  = 3'd5;

    // Read sequence: step 0 fetches the voxel itself, steps 1 to 6 the
    // neighbours, and step 7 only collects the last read.
    localparam logic [2:0] STEP_LAST_ISSUE = 3'd6;
    localparam logic [2:0] STEP_DONE       = 3'd7;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    // Coordinates one bit wider than the ports, so that a step off either
    // edge of the chunk lands outside it.
    typedef struct packed {
        logic [8:0] x;
        logic [8:0] y;
        logic [8:0] z;
    } coord_t;

    function automatic logic in_chunk(input coord_t c);
        return (c.x < 9'(CHUNK_W)) && (c.y < 9'(CHUNK_H)) && (c.z < 9'(CHUNK_D));
    endfunction

    function automatic logic [VOXEL_AW-1:0] voxel_index(input coord_t c);
        return VOXEL_AW'(32'(c.x) + CHUNK_W * (32'(c.y) + CHUNK_H * 32'(c.z)));
    endfunction

    function automatic coord_t neighbour(input logic [FACE_W-1:0] face,
                                         input coord_t c);
        coord_t n;
        n = c;
        unique case (face)
            FACE_TOP:    n.y = c.y + 9'd1;
            FACE_BOTTOM: n.y = c.y - 9'd1;
            FACE_POS_Z:  n.z = c.z + 9'd1;
            FACE_NEG_Z:  n.z = c.z - 9'd1;
            FACE_NEG_X:  n.x = c.x - 9'd1;
            FACE_POS_X:  n.x = c.x + 9'd1;
            default:     n = c;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/voxel_face_culling_mesher_core.sv =====
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher_core
// Voxel chunk store with per-voxel face culling against a transparency mask.
// ----------------------------------------------------------------------------
// The core holds a 16 x 64 x 16 chunk of 6-bit block types in one
// single-port synchronous memory. After reset it sweeps the memory to air,
// one entry per cycle; item_stall stays high during that pass, while
// configuration writes are taken as usual. A write or clear item is
// handled in the idle state and produces no result. A mesh item reads the
// voxel and its six neighbours one after another through the single memory
// port, whose read data is registered, and then hands out its one to six
// results, one per cycle while the output side does not stall. Only one
// item is in the core at a time. Results leave through an output register,
// so the last result of an item may wait there while the next item is
// accepted.
// The transparency mask may be written whenever the core is idle.
module voxel_face_culling_mesher_core
    import vfcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Command items.
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [1:0]           cmd,
    input  logic [7:0]           pos_x,
    input  logic [7:0]           pos_y,
    input  logic [7:0]           pos_z,
    input  logic [TYPE_W-1:0]    block_type,

    // Face result items.
    output logic                 face_valid,
    input  logic                 face_stall,
    output logic                 visible,
    output logic [FACE_W-1:0]    face_id,
    output logic [TYPE_W-1:0]    voxel_type,
    output logic [VBASE_W-1:0]   vertex_base,
    output logic                 last,

    // Transparency mask write port.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [MASK_W-1:0]    cfg_data
);

    // Voxel memory, single port, registered read data.
    logic [TYPE_W-1:0]   voxel_mem [VOXEL_COUNT];
    logic [TYPE_W-1:0]   mem_rdata;
    logic                mem_we;
    logic                mem_re;
    logic [VOXEL_AW-1:0] mem_addr;
    logic [TYPE_W-1:0]   mem_wdata;

    state_t               state_reg, state_next;
    logic [VOXEL_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [2:0]           step_reg, step_next;
    coord_t               pos_reg, pos_next;
    logic                 rd_oob_reg, rd_oob_next;
    logic [TYPE_W-1:0]    self_type_reg, self_type_next;
    logic [NUM_FACES-1:0] vis_reg, vis_next;
    logic [COUNTER_W-1:0] cnt_reg, cnt_next;
    logic [MASK_W-1:0]    mask_reg;

    logic                 face_valid_reg, face_valid_next;
    logic                 visible_reg, visible_next;
    logic [FACE_W-1:0]    face_id_reg, face_id_next;
    logic [TYPE_W-1:0]    voxel_type_reg, voxel_type_next;
    logic [VBASE_W-1:0]   vertex_base_reg, vertex_base_next;
    logic                 last_reg, last_next;

    logic                 item_accept;
    logic                 out_load;
    logic                 clear_done;
    logic                 emit_final;
    logic [NUM_FACES-1:0] vis_rest;
    logic [FACE_W-1:0]    low_face;
    coord_t               wr_coord;
    coord_t               rd_coord;
    logic                 rd_in_chunk;
    logic [TYPE_W-1:0]    rd_type;

    assign item_accept = item_valid && !item_stall;
    assign out_load    = !face_valid_reg || !face_stall;
    assign clear_done  = (clr_cnt_reg == VOXEL_AW'(VOXEL_COUNT - 1));

    // Remaining faces once the lowest visible one has gone out.
    assign vis_rest   = vis_reg & (vis_reg - NUM_FACES'(1));
    assign emit_final = (self_type_reg == '0) || (vis_rest == '0);

    always_comb
    begin
        low_face = '0;
        for (int i = NUM_FACES - 1; i >= 0; i--)
        begin
            if (vis_reg[i])
            begin
                low_face = FACE_W'(i);
            end
        end
    end

    assign wr_coord = '{x: {1'b0, pos_x}, y: {1'b0, pos_y}, z: {1'b0, pos_z}};

    // Step 0 reads the voxel itself, later steps read the neighbours.
    assign rd_coord    = (step_reg == '0) ? pos_reg
                                          : neighbour(FACE_W'(step_reg - 3'd1), pos_reg);
    assign rd_in_chunk = in_chunk(rd_coord);
    assign rd_type     = rd_oob_reg ? '0 : mem_rdata;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_accept && (cmd == CMD_MESH))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (step_reg == STEP_DONE)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load && emit_final)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        clr_cnt_next     = clr_cnt_reg;
        step_next        = step_reg;
        pos_next         = pos_reg;
        rd_oob_next      = rd_oob_reg;
        self_type_next   = self_type_reg;
        vis_next         = vis_reg;
        cnt_next         = cnt_reg;
        face_valid_next  = face_valid_reg && face_stall;
        visible_next     = visible_reg;
        face_id_next     = face_id_reg;
        voxel_type_next  = voxel_type_reg;
        vertex_base_next = vertex_base_reg;
        last_next        = last_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_addr         = clr_cnt_reg;
        mem_wdata        = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + VOXEL_AW'(1);
            end
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    unique case (cmd)
                        CMD_WRITE:
                        begin
                            if (in_chunk(wr_coord))
                            begin
                                mem_we    = 1'b1;
                                mem_addr  = voxel_index(wr_coord);
                                mem_wdata = block_type;
                            end
                        end
                        CMD_MESH:
                        begin
                            pos_next  = wr_coord;
                            step_next = '0;
                        end
                        CMD_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (step_reg <= STEP_LAST_ISSUE)
                begin
                    mem_re      = rd_in_chunk;
                    mem_addr    = voxel_index(rd_coord);
                    rd_oob_next = !rd_in_chunk;
                end
                if (step_reg == 3'd1)
                begin
                    self_type_next = rd_type;
                end
                else if (step_reg >= 3'd2)
                begin
                    vis_next[step_reg - 3'd2] = mask_reg[rd_type];
                end
                step_next = step_reg + 3'd1;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    face_valid_next = 1'b1;
                    voxel_type_next = self_type_reg;
                    last_next       = emit_final;
                    if ((self_type_reg == '0) || (vis_reg == '0))
                    begin
                        visible_next     = 1'b0;
                        face_id_next     = FACE_TOP;
                        vertex_base_next = '0;
                    end
                    else
                    begin
                        visible_next     = 1'b1;
                        face_id_next     = low_face;
                        vertex_base_next = {cnt_reg, 2'b00};
                        vis_next         = vis_rest;
                        cnt_next         = cnt_reg + COUNTER_W'(1);
                    end
                end
            end
        endcase
    end

    // Port outputs.
    always_comb
    begin
        item_stall  = (state_reg != ST_IDLE);
        cfg_ready   = 1'b1;
        face_valid  = face_valid_reg;
        visible     = visible_reg;
        face_id     = face_id_reg;
        voxel_type  = voxel_type_reg;
        vertex_base = vertex_base_reg;
        last        = last_reg;
    end

    // Voxel memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            voxel_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= voxel_mem[mem_addr];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            step_reg       <= '0;
            cnt_reg        <= '0;
            mask_reg       <= MASK_W'(1);
            face_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            step_reg       <= step_next;
            cnt_reg        <= cnt_next;
            face_valid_reg <= face_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                mask_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        rd_oob_reg      <= rd_oob_next;
        self_type_reg   <= self_type_next;
        vis_reg         <= vis_next;
        visible_reg     <= visible_next;
        face_id_reg     <= face_id_next;
        voxel_type_reg  <= voxel_type_next;
        vertex_base_reg <= vertex_base_next;
        last_reg        <= last_next;
    end

    // A mesh item always starts the read sequence at the voxel itself.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && (cmd == CMD_MESH) |=> (state_reg == ST_READ) && (step_reg == '0))
        else $error("mesh item did not start the read sequence");

    // The memory is never written while a query is reading it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) || (state_reg == ST_EMIT) |-> !mem_we)
        else $error("voxel memory written during a query");

    // Each visible face handed out advances the face counter by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && out_load && (self_type_reg != '0) && (vis_reg != '0)
        |=> (cnt_reg == COUNTER_W'($past(cnt_reg) + COUNTER_W'(1))))
        else $error("face counter did not step with a visible face");

    // No result is produced before the clearing pass has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !face_valid_reg)
        else $error("result produced during clearing pass");

endmodule

// ===== verif/voxel_face_culling_mesher_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher_core_tb
// Self-checking bench for the voxel face culling core. It keeps its own
// copy of the chunk, the face counter and the transparency mask. From these it
// works out the face results of every accepted item. Each face result from
// the core is compared with the oldest expected one. A short directed table
// is followed by randomised phases under several mask settings and a closing
// run of single-voxel queries sent back to back.
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher_core_tb
    import vfcm_pkg::*;
;

    // Command code the core has no use for; such items must be dropped.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int NUM_PHASES      = 5;
    localparam int ITEMS_PER_PHASE = 16;
    // Six faces per query, so each of these moves the vertex base on by 24.
    localparam int SOAK_QUERIES    = 12;

    typedef struct packed {
        logic                visible;
        logic [FACE_W-1:0]   face_id;
        logic [TYPE_W-1:0]   voxel_type;
        logic [VBASE_W-1:0]  vertex_base;
        logic                last;
    } face_res_t;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [7:0]          x;
        logic [7:0]          y;
        logic [7:0]          z;
        logic [TYPE_W-1:0]   btype;
        logic                typed;
        face_res_t           res;
    } probe_row_t;

    // Neighbour steps, in the order the core hands out faces.
    localparam logic [FACE_W-1:0] FACE_ORDER [NUM_FACES] =
        '{FACE_TOP, FACE_BOTTOM, FACE_POS_Z, FACE_NEG_Z, FACE_NEG_X, FACE_POS_X};
    localparam int NB_DX [NUM_FACES] = '{0, 0, 0, 0, -1, 1};
    localparam int NB_DY [NUM_FACES] = '{1, -1, 0, 0, 0, 0};
    localparam int NB_DZ [NUM_FACES] = '{0, 0, 1, -1, 0, 0};

    // An air voxel, or one outside the chunk, answers with this single result.
    localparam face_res_t AIR_RESULT = '{1'b0, FACE_TOP, 6'd0, 16'd0, 1'b1};
    // A type 3 voxel walled in on all six sides by opaque type 2.
    localparam face_res_t ENCLOSED_RESULT = '{1'b0, FACE_TOP, 6'd3, 16'd0, 1'b1};

    // Directed items. Rows with typed set carry a result that is plain from
    // the behaviour; all other rows are checked against the predictor. The
    // mask keeps its reset value throughout, so only air is transparent.
    localparam int DIRECTED_COUNT = 26;
    localparam probe_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Fresh chunk: everything reads as air, inside or out.
        '{CMD_MESH,   8'd0,   8'd0,   8'd0,   6'd0,  1'b1, AIR_RESULT},
        '{CMD_MESH,   8'd255, 8'd255, 8'd255, 6'd0,  1'b1, AIR_RESULT},
        '{CMD_MESH,   8'd15,  8'd63,  8'd15,  6'd0,  1'b1, AIR_RESULT},
        // Opposite corners, highest and lowest solid type.
        '{CMD_WRITE,  8'd0,   8'd0,   8'd0,   6'd63, 1'b0, '0},
        '{CMD_MESH,   8'd0,   8'd0,   8'd0,   6'd0,  1'b0, '0},
        '{CMD_WRITE,  8'd15,  8'd63,  8'd15,  6'd1,  1'b0, '0},
        '{CMD_MESH,   8'd15,  8'd63,  8'd15,  6'd0,  1'b0, '0},
        // Writes just past each edge are dropped; the spot still reads air.
        '{CMD_WRITE,  8'd16,  8'd0,   8'd0,   6'd5,  1'b0, '0},
        '{CMD_MESH,   8'd16,  8'd0,   8'd0,   6'd0,  1'b1, AIR_RESULT},
        '{CMD_WRITE,  8'd0,   8'd64,  8'd0,   6'd7,  1'b0, '0},
        '{CMD_MESH,   8'd0,   8'd64,  8'd0,   6'd0,  1'b1, AIR_RESULT},
        '{CMD_WRITE,  8'd0,   8'd0,   8'd16,  6'd9,  1'b0, '0},
        '{CMD_MESH,   8'd0,   8'd0,   8'd16,  6'd0,  1'b1, AIR_RESULT},
        // Counter clear with junk fields, then the unused code.
        '{CMD_CLEAR,  8'd170, 8'd85,  8'd255, 6'd42, 1'b0, '0},
        '{CMD_UNUSED, 8'd85,  8'd170, 8'd0,   6'd21, 1'b0, '0},
        // Wall in (5,5,5) so that it shows no face at all.
        '{CMD_WRITE,  8'd5,   8'd6,   8'd5,   6'd2,  1'b0, '0},
        '{CMD_WRITE,  8'd5,   8'd4,   8'd5,   6'd2,  1'b0, '0},
        '{CMD_WRITE,  8'd5,   8'd5,   8'd6,   6'd2,  1'b0, '0},
        '{CMD_WRITE,  8'd5,   8'd5,   8'd4,   6'd2,  1'b0, '0},
        '{CMD_WRITE,  8'd4,   8'd5,   8'd5,   6'd2,  1'b0, '0},
        '{CMD_WRITE,  8'd6,   8'd5,   8'd5,   6'd2,  1'b0, '0},
        '{CMD_WRITE,  8'd5,   8'd5,   8'd5,   6'd3,  1'b0, '0},
        '{CMD_MESH,   8'd5,   8'd5,   8'd5,   6'd0,  1'b1, ENCLOSED_RESULT},
        // Knock out the block above: only the top face opens up.
        '{CMD_WRITE,  8'd5,   8'd6,   8'd5,   6'd0,  1'b0, '0},
        '{CMD_MESH,   8'd5,   8'd5,   8'd5,   6'd0,  1'b0, '0},
        // The corner again, counting on from the cleared counter.
        '{CMD_MESH,   8'd0,   8'd0,   8'd0,   6'd0,  1'b0, '0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    logic [1:0]           cmd;
    logic [7:0]           pos_x;
    logic [7:0]           pos_y;
    logic [7:0]           pos_z;
    logic [TYPE_W-1:0]    block_type;
    logic                 face_valid;
    logic                 face_stall;
    logic                 visible;
    logic [FACE_W-1:0]    face_id;
    logic [TYPE_W-1:0]    voxel_type;
    logic [VBASE_W-1:0]   vertex_base;
    logic                 last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [MASK_W-1:0]    cfg_data;

    // Predictor state: the chunk, the face counter and the mask.
    bit [TYPE_W-1:0]      chunk_types [VOXEL_COUNT];
    bit [COUNTER_W-1:0]   face_tally;
    bit [MASK_W-1:0]      see_through;

    // Face results still owed by the core, oldest first.
    face_res_t            pending_faces [$];

    int unsigned          idle_pct = 30;
    int                   cycle_count = 0;
    int                   mismatch_count = 0;
    int                   items_sent = 0;
    int                   faces_checked = 0;
    int                   visible_faces = 0;
    int                   mask_writes = 0;

    voxel_face_culling_mesher_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .block_type  (block_type),
        .face_valid  (face_valid),
        .face_stall  (face_stall),
        .visible     (visible),
        .face_id     (face_id),
        .voxel_type  (voxel_type),
        .vertex_base (vertex_base),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // A hung core is caught here.
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Length of the next idle burst, or zero for none.
    function automatic int unsigned idle_burst();
        if ($urandom_range(1, 100) <= idle_pct)
            return $urandom_range(1, 11);
        return 0;
    endfunction

    // Block type held at a position; anything outside the chunk is air.
    function automatic bit [TYPE_W-1:0] stored_type(input int x, input int y, input int z);
        if (x < 0 || x >= CHUNK_W || y < 0 || y >= CHUNK_H || z < 0 || z >= CHUNK_D)
            return '0;
        return chunk_types[x + CHUNK_W * (y + CHUNK_H * z)];
    endfunction

    // Applies one item to the predictor state and lists the face results that
    // it should produce, in order.
    task automatic cull_faces(input logic [1:0] c, input logic [7:0] x, input logic [7:0] y,
                              input logic [7:0] z, input logic [TYPE_W-1:0] bt,
                              ref face_res_t faces [$]);
        bit [TYPE_W-1:0] self_type;
        bit [TYPE_W-1:0] nb_type;
        faces.delete();
        case (c)
            CMD_WRITE:
            begin
                if (int'(x) < CHUNK_W && int'(y) < CHUNK_H && int'(z) < CHUNK_D)
                    chunk_types[int'(x) + CHUNK_W * (int'(y) + CHUNK_H * int'(z))] = bt;
            end
            CMD_CLEAR:
            begin
                face_tally = '0;
            end
            CMD_MESH:
            begin
                self_type = stored_type(int'(x), int'(y), int'(z));
                if (self_type == '0)
                begin
                    faces.push_back(AIR_RESULT);
                end
                else
                begin
                    // The voxel's own transparency plays no part; only the
                    // neighbours decide which faces show.
                    for (int f = 0; f < NUM_FACES; f++)
                    begin
                        nb_type = stored_type(int'(x) + NB_DX[f], int'(y) + NB_DY[f],
                                              int'(z) + NB_DZ[f]);
                        if (see_through[nb_type])
                        begin
                            faces.push_back('{1'b1, FACE_ORDER[f], self_type,
                                              {face_tally, 2'b00}, 1'b0});
                            face_tally = face_tally + 1'b1;
                        end
                    end
                    if (faces.size() == 0)
                        faces.push_back('{1'b0, FACE_TOP, self_type, 16'd0, 1'b1});
                    else
                        faces[faces.size() - 1].last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Offers one item, waits for it to be taken and records what it owes.
    // A typed row's written-down result stands in for the predicted one.
    task automatic send_item(input logic [1:0] c, input logic [7:0] x, input logic [7:0] y,
                             input logic [7:0] z, input logic [TYPE_W-1:0] bt,
                             input logic typed, input face_res_t typed_res);
        face_res_t fresh [$];
        int unsigned gap;
        gap = idle_burst();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd        <= c;
        pos_x      <= x;
        pos_y      <= y;
        pos_z      <= z;
        block_type <= bt;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        cull_faces(c, x, y, z, bt, fresh);
        if (typed)
            pending_faces.push_back(typed_res);
        else
            foreach (fresh[i]) pending_faces.push_back(fresh[i]);
        items_sent++;
    endtask

    // Writes the transparency mask and mirrors it in the predictor.
    task automatic write_mask(input logic [MASK_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid   <= 1'b0;
        see_through = value;
        mask_writes++;
    endtask

    // Stops offering items, lets every owed result arrive and then allows a
    // few more cycles for a write or clear that may still be in the core.
    task automatic wait_results_done();
        item_valid <= 1'b0;
        while (pending_faces.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Lower corner of a 4-wide box; edges of the chunk are favoured so that
    // out-of-chunk neighbours come up often.
    function automatic int pick_anchor(input int extent);
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return extent - 4;
            default: return $urandom_range(0, extent - 4);
        endcase
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // The result side stalls in random bursts.
    initial
    begin : face_backpressure
        int unsigned hold;
        face_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            hold = idle_burst();
            if (hold != 0)
            begin
                face_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                face_stall <= 1'b0;
            end
        end
    end

    // Every face item the core hands over is checked against the oldest
    // expected one, field by field.
    always @(posedge clk)
    begin : face_check
        face_res_t want;
        if (rst_n && face_valid && !face_stall)
        begin
            if (pending_faces.size() == 0)
            begin
                $error("face item with none expected: face_id %0d, voxel_type %0d",
                       face_id, voxel_type);
                mismatch_count++;
            end
            else
            begin
                want = pending_faces.pop_front();
                faces_checked++;
                if (visible)
                    visible_faces++;
                compare_field("visible", want.visible, visible);
                compare_field("face_id", want.face_id, face_id);
                compare_field("voxel_type", want.voxel_type, voxel_type);
                compare_field("vertex_base", want.vertex_base, vertex_base);
                compare_field("last", want.last, last);
            end
        end
    end

    initial
    begin : stimulus
        logic [MASK_W-1:0] phase_mask;
        logic [TYPE_W-1:0] fill;
        int                ax;
        int                ay;
        int                az;
        int unsigned       roll;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        cmd        = CMD_WRITE;
        pos_x      = '0;
        pos_y      = '0;
        pos_z      = '0;
        block_type = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        face_tally  = '0;
        see_through = 64'd1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // The directed table runs with the mask at its reset value. The core
        // holds item_stall high while it sweeps its store to air, so the
        // first item simply waits for that to finish.
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].y,
                      DIRECTED_ROWS[i].z, DIRECTED_ROWS[i].btype, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].res);

        // Random phases, each under its own mask: nothing transparent, two
        // random masks, the reset value written back and everything
        // transparent. Most items land in one small box so that writes and
        // queries meet; the rest are scattered over the whole coordinate
        // range, which mostly lies outside the chunk.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       phase_mask = '0;
                1:       phase_mask = {$urandom, $urandom};
                2:       phase_mask = {$urandom, $urandom} | 64'd1;
                3:       phase_mask = 64'd1;
                default: phase_mask = '1;
            endcase
            wait_results_done();
            write_mask(phase_mask);
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 30;
            endcase
            ax = pick_anchor(CHUNK_W);
            ay = pick_anchor(CHUNK_H);
            az = pick_anchor(CHUNK_D);
            repeat (ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(0, 99);
                fill = ($urandom_range(0, 4) == 0) ? '0 : TYPE_W'($urandom_range(1, 63));
                if (roll < 40)
                    send_item(CMD_WRITE, 8'(ax + $urandom_range(0, 3)),
                              8'(ay + $urandom_range(0, 3)), 8'(az + $urandom_range(0, 3)),
                              fill, 1'b0, '0);
                else if (roll < 80)
                    // One step either side of the box, so a box on the edge
                    // also queries positions just outside the chunk.
                    send_item(CMD_MESH, 8'(ax + int'($urandom_range(0, 5)) - 1),
                              8'(ay + int'($urandom_range(0, 5)) - 1),
                              8'(az + int'($urandom_range(0, 5)) - 1),
                              TYPE_W'($urandom), 1'b0, '0);
                else if (roll < 88)
                    send_item(CMD_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
                              TYPE_W'($urandom), 1'b0, '0);
                else if (roll < 94)
                    send_item(CMD_MESH, 8'($urandom), 8'($urandom), 8'($urandom),
                              TYPE_W'($urandom), 1'b0, '0);
                else if (roll < 97)
                    send_item(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                              TYPE_W'($urandom), 1'b0, '0);
                else
                    send_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                              TYPE_W'($urandom), 1'b0, '0);
            end
        end

        // Final stretch, with no idling on either side: everything is still
        // transparent, so one solid voxel shows six faces per query and the
        // queries follow one another as fast as the core takes them.
        idle_pct = 0;
        send_item(CMD_WRITE, 8'd8, 8'd8, 8'd8, 6'd33, 1'b0, '0);
        repeat (SOAK_QUERIES)
            send_item(CMD_MESH, 8'd8, 8'd8, 8'd8, 6'd0, 1'b0, '0);

        wait_results_done();

        $display("Run covered %0d items and %0d face results (%0d visible).",
                 items_sent, faces_checked, visible_faces);
        $display("Mask written %0d times; the last stretch ran full-face queries unstalled.",
                 mask_writes);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
